[sv/swtps_pkg.sv]
// shared types, constants and codes for the sorted word table
`default_nettype none
package swtps_pkg;

    localparam int MAX_WORDS  = 64;
    localparam int MAX_LEN    = 32;
    localparam int PREFIX_LEN = 4;
    localparam int KEY_BYTES  = 4;

    localparam int WORD_AW = $clog2(MAX_WORDS);
    localparam int LEN_AW  = $clog2(MAX_LEN);
    localparam int CHAR_AW = WORD_AW + LEN_AW;
    localparam int CNT_W   = $clog2(MAX_WORDS + 1);
    localparam int WLEN_W  = 6;
    localparam int KSEL_W  = $clog2(KEY_BYTES);

    localparam logic [1:0] CMD_TEXT   = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_FOUND   = 3'd2;
    localparam logic [2:0] ST_MISS    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_EXCLAIM = 8'h21;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  text_char;
        logic [31:0] search_key;
        logic [2:0]  key_length;
        logic        match_case;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] position;
        logic [5:0] word_len;
        logic [7:0] out_char;
        logic       last;
    } result_t;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ORD,
        S_SLOT,
        S_LEN,
        S_WL,
        S_IRD,
        S_ICMP,
        S_CPRD,
        S_CPWR,
        S_SHRD,
        S_SHWR,
        S_IDONE,
        S_SRD,
        S_SCMP,
        S_OUTRD,
        S_OUTEM
    } state_t;

endpackage
`default_nettype wire

[sv/swtps_cmp.sv]
// shared byte compare unit with optional ascii case folding
`default_nettype none
module swtps_cmp (
    input  wire logic [7:0]        a,
    input  wire logic [7:0]        b,
    input  wire logic              fold,
    output swtps_pkg::cmp_res_t    res
);
    logic [7:0] fa;
    logic [7:0] fb;

    always_comb
    begin
        fa = a;
        fb = b;
        if (fold && a >= 8'h41 && a <= 8'h5A)
        begin
            fa = a + 8'd32;
        end
        if (fold && b >= 8'h41 && b <= 8'h5A)
        begin
            fb = b + 8'd32;
        end
        res.eq = (fa == fb);
        res.lt = (fa < fb);
    end
endmodule
`default_nettype wire

[sv/sorted_word_table_prefix_search.sv]
// top level: word gathering, sorted insertion and prefix search sequencer
// one item at a time; clear, table-full drop and bad key beat next cycle
// insertion: each word passed is fetched and its bytes compared, then the pending bytes
// are copied in and the order entries shifted up; busy is high throughout
// search: key compared with each word scanned, then one found beat per byte, no stall
// reset clears the sequencer, word count and pending length; stores need no clearing
`default_nettype none
module sorted_word_table_prefix_search (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire swtps_pkg::item_t   item,
    output logic                    strobe,
    output swtps_pkg::result_t      result
);
    // storage: all read through registered ports
    logic [7:0]                        char_mem  [swtps_pkg::MAX_WORDS*swtps_pkg::MAX_LEN];
    logic [swtps_pkg::WLEN_W-1:0]      len_mem   [swtps_pkg::MAX_WORDS];
    logic [swtps_pkg::WORD_AW-1:0]     order_mem [swtps_pkg::MAX_WORDS];
    logic [7:0]                        pend_mem  [swtps_pkg::MAX_LEN];

    logic [7:0]                        char_q;
    logic [swtps_pkg::WLEN_W-1:0]      len_q;
    logic [swtps_pkg::WORD_AW-1:0]     order_q;
    logic [7:0]                        pend_q;

    logic [swtps_pkg::CHAR_AW-1:0]     char_raddr;
    logic [swtps_pkg::CHAR_AW-1:0]     char_waddr;
    logic                              char_we;
    logic [swtps_pkg::WORD_AW-1:0]     order_raddr;
    logic [swtps_pkg::WORD_AW-1:0]     order_waddr;
    logic [swtps_pkg::WORD_AW-1:0]     order_wdata;
    logic                              order_we;
    logic                              len_we;
    logic [swtps_pkg::LEN_AW-1:0]      pend_raddr;
    logic                              pend_we;

    // sequencer and datapath registers
    swtps_pkg::state_t                 state_reg, state_next;
    logic [swtps_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [swtps_pkg::CNT_W-1:0]       pos_reg, pos_next;
    logic [swtps_pkg::CNT_W-1:0]       sh_reg, sh_next;
    logic [swtps_pkg::WLEN_W-1:0]      byte_reg, byte_next;
    logic [swtps_pkg::WLEN_W-1:0]      plen_reg, plen_next;
    logic [swtps_pkg::WORD_AW-1:0]     slot_reg, slot_next;
    logic [swtps_pkg::WLEN_W-1:0]      wl_reg, wl_next;
    logic                              search_reg, search_next;
    logic [swtps_pkg::KEY_BYTES-1:0][7:0] key_reg, key_next;
    logic [2:0]                        klen_reg, klen_next;
    logic                              exact_reg, exact_next;
    logic                              strobe_reg, strobe_next;
    swtps_pkg::result_t                result_reg, result_next;

    // item decode
    logic accept;
    logic is_skip;
    logic is_term;
    logic key_bad;
    logic [swtps_pkg::WLEN_W-1:0] n_ins;
    logic [swtps_pkg::WLEN_W-1:0] n_srch;

    // shared compare unit
    logic [7:0]              cmp_a;
    logic [7:0]              cmp_b;
    logic                    cmp_fold;
    swtps_pkg::cmp_res_t     cmp_res;

    assign accept  = start && (state_reg == swtps_pkg::S_IDLE);
    assign busy    = (state_reg != swtps_pkg::S_IDLE);
    assign strobe  = strobe_reg;
    assign result  = result_reg;

    assign is_skip = (item.text_char == swtps_pkg::CH_COMMA)
                  || (item.text_char == swtps_pkg::CH_DQUOTE)
                  || (item.text_char == swtps_pkg::CH_APOS);
    // space, newline and sentence ends all close the pending word
    assign is_term = (item.text_char == swtps_pkg::CH_SPACE)
                  || (item.text_char == swtps_pkg::CH_PERIOD)
                  || (item.text_char == swtps_pkg::CH_QUEST)
                  || (item.text_char == swtps_pkg::CH_EXCLAIM)
                  || (item.text_char == swtps_pkg::CH_NL);
    assign key_bad = (item.key_length == 3'd0)
                  || (32'(item.key_length) > swtps_pkg::KEY_BYTES)
                  || (32'(item.key_length) > swtps_pkg::PREFIX_LEN);

    // bytes compared on insertion: shorter of stored and pending word
    assign n_ins  = (wl_reg < plen_reg) ? wl_reg : plen_reg;
    // prefix span of a stored word for search
    assign n_srch = (len_q < swtps_pkg::WLEN_W'(swtps_pkg::PREFIX_LEN))
                  ? len_q : swtps_pkg::WLEN_W'(swtps_pkg::PREFIX_LEN);

    // insertion compares stored byte against pending byte, search compares key byte
    always_comb
    begin
        if (state_reg == swtps_pkg::S_ICMP)
        begin
            cmp_a    = char_q;
            cmp_b    = pend_q;
            cmp_fold = 1'b0;
        end
        else
        begin
            cmp_a    = key_reg[byte_reg[swtps_pkg::KSEL_W-1:0]];
            cmp_b    = char_q;
            cmp_fold = !exact_reg;
        end
    end

    swtps_cmp u_cmp (
        .a    (cmp_a),
        .b    (cmp_b),
        .fold (cmp_fold),
        .res  (cmp_res)
    );

    // memory addressing
    always_comb
    begin
        char_raddr  = {slot_reg, byte_reg[swtps_pkg::LEN_AW-1:0]};
        char_waddr  = {count_reg[swtps_pkg::WORD_AW-1:0], byte_reg[swtps_pkg::LEN_AW-1:0]};
        char_we     = (state_reg == swtps_pkg::S_CPWR);
        pend_raddr  = byte_reg[swtps_pkg::LEN_AW-1:0];
        pend_we     = accept && (item.command == swtps_pkg::CMD_TEXT) && !is_skip
                   && !is_term && (32'(plen_reg) < swtps_pkg::MAX_LEN);
        len_we      = (state_reg == swtps_pkg::S_IDONE);
        order_we    = 1'b0;
        order_waddr = sh_reg[swtps_pkg::WORD_AW-1:0];
        order_wdata = order_q;
        if (state_reg == swtps_pkg::S_SHRD || state_reg == swtps_pkg::S_SHWR)
        begin
            order_raddr = swtps_pkg::WORD_AW'(sh_reg - 1'b1);
        end
        else
        begin
            order_raddr = pos_reg[swtps_pkg::WORD_AW-1:0];
        end
        if (state_reg == swtps_pkg::S_SHWR)
        begin
            order_we = 1'b1;
        end
        else if (state_reg == swtps_pkg::S_IDONE)
        begin
            order_we    = 1'b1;
            order_waddr = pos_reg[swtps_pkg::WORD_AW-1:0];
            order_wdata = count_reg[swtps_pkg::WORD_AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[char_waddr] <= pend_q;
        end
        char_q <= char_mem[char_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[count_reg[swtps_pkg::WORD_AW-1:0]] <= plen_reg;
        end
        len_q <= len_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[order_waddr] <= order_wdata;
        end
        order_q <= order_mem[order_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[plen_reg[swtps_pkg::LEN_AW-1:0]] <= item.text_char;
        end
        pend_q <= pend_mem[pend_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swtps_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == swtps_pkg::CMD_TEXT && is_term && plen_reg != '0
                        && 32'(count_reg) < swtps_pkg::MAX_WORDS)
                    begin
                        state_next = swtps_pkg::S_ORD;
                    end
                    else if (item.command == swtps_pkg::CMD_SEARCH && !key_bad)
                    begin
                        state_next = swtps_pkg::S_ORD;
                    end
                end
            end
            swtps_pkg::S_ORD:
            begin
                if (pos_reg == count_reg)
                begin
                    state_next = search_reg ? swtps_pkg::S_IDLE : swtps_pkg::S_CPRD;
                end
                else
                begin
                    state_next = swtps_pkg::S_SLOT;
                end
            end
            swtps_pkg::S_SLOT: state_next = swtps_pkg::S_LEN;
            swtps_pkg::S_LEN:  state_next = swtps_pkg::S_WL;
            swtps_pkg::S_WL:
            begin
                if (!search_reg)
                begin
                    state_next = swtps_pkg::S_IRD;
                end
                else if (n_srch == 6'(klen_reg))
                begin
                    state_next = swtps_pkg::S_SRD;
                end
                else
                begin
                    state_next = swtps_pkg::S_ORD;
                end
            end
            swtps_pkg::S_IRD:
            begin
                if (byte_reg == n_ins)
                begin
                    state_next = (wl_reg <= plen_reg) ? swtps_pkg::S_ORD : swtps_pkg::S_CPRD;
                end
                else
                begin
                    state_next = swtps_pkg::S_ICMP;
                end
            end
            swtps_pkg::S_ICMP:
            begin
                if (cmp_res.eq)
                begin
                    state_next = swtps_pkg::S_IRD;
                end
                else
                begin
                    state_next = cmp_res.lt ? swtps_pkg::S_ORD : swtps_pkg::S_CPRD;
                end
            end
            swtps_pkg::S_CPRD:
            begin
                state_next = (byte_reg == plen_reg) ? swtps_pkg::S_SHRD : swtps_pkg::S_CPWR;
            end
            swtps_pkg::S_CPWR: state_next = swtps_pkg::S_CPRD;
            swtps_pkg::S_SHRD:
            begin
                state_next = (sh_reg == pos_reg) ? swtps_pkg::S_IDONE : swtps_pkg::S_SHWR;
            end
            swtps_pkg::S_SHWR:  state_next = swtps_pkg::S_SHRD;
            swtps_pkg::S_IDONE: state_next = swtps_pkg::S_IDLE;
            swtps_pkg::S_SRD:
            begin
                state_next = (byte_reg == 6'(klen_reg)) ? swtps_pkg::S_OUTRD : swtps_pkg::S_SCMP;
            end
            swtps_pkg::S_SCMP:
            begin
                state_next = cmp_res.eq ? swtps_pkg::S_SRD : swtps_pkg::S_ORD;
            end
            swtps_pkg::S_OUTRD: state_next = swtps_pkg::S_OUTEM;
            swtps_pkg::S_OUTEM:
            begin
                if (byte_reg + 1'b1 == wl_reg)
                begin
                    state_next = swtps_pkg::S_IDLE;
                end
                else
                begin
                    state_next = swtps_pkg::S_OUTRD;
                end
            end
            default: state_next = swtps_pkg::S_IDLE;
        endcase
    end

    // datapath updates and result beats
    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        sh_next     = sh_reg;
        byte_next   = byte_reg;
        plen_next   = plen_reg;
        slot_next   = slot_reg;
        wl_next     = wl_reg;
        search_next = search_reg;
        key_next    = key_reg;
        klen_next   = klen_reg;
        exact_next  = exact_reg;
        strobe_next = 1'b0;
        result_next = '0;
        unique case (state_reg)
            swtps_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    pos_next    = '0;
                    key_next    = item.search_key;
                    klen_next   = item.key_length;
                    exact_next  = item.match_case;
                    search_next = (item.command == swtps_pkg::CMD_SEARCH);
                    case (item.command)
                        swtps_pkg::CMD_TEXT:
                        begin
                            if (is_term)
                            begin
                                if (plen_reg != '0
                                    && 32'(count_reg) >= swtps_pkg::MAX_WORDS)
                                begin
                                    // table full: word dropped
                                    strobe_next          = 1'b1;
                                    result_next.status   = swtps_pkg::ST_FULL;
                                    result_next.word_len = plen_reg;
                                    result_next.last     = 1'b1;
                                    plen_next            = '0;
                                end
                            end
                            else if (!is_skip && 32'(plen_reg) < swtps_pkg::MAX_LEN)
                            begin
                                plen_next = plen_reg + 1'b1;
                            end
                        end
                        swtps_pkg::CMD_SEARCH:
                        begin
                            if (key_bad)
                            begin
                                strobe_next        = 1'b1;
                                result_next.status = swtps_pkg::ST_MISS;
                                result_next.last   = 1'b1;
                            end
                        end
                        swtps_pkg::CMD_CLEAR:
                        begin
                            count_next         = '0;
                            plen_next          = '0;
                            strobe_next        = 1'b1;
                            result_next.status = swtps_pkg::ST_CLEARED;
                            result_next.last   = 1'b1;
                        end
                        default:
                        begin
                            search_next = search_reg;
                        end
                    endcase
                end
            end
            swtps_pkg::S_ORD:
            begin
                byte_next = '0;
                if (pos_reg == count_reg && search_reg)
                begin
                    strobe_next        = 1'b1;
                    result_next.status = swtps_pkg::ST_MISS;
                    result_next.last   = 1'b1;
                end
            end
            swtps_pkg::S_SLOT:
            begin
                slot_next = order_q;
            end
            swtps_pkg::S_LEN:
            begin
                byte_next = '0;
            end
            swtps_pkg::S_WL:
            begin
                wl_next = len_q;
                if (search_reg && n_srch != 6'(klen_reg))
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            swtps_pkg::S_IRD:
            begin
                if (byte_reg == n_ins)
                begin
                    if (wl_reg <= plen_reg)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    byte_next = '0;
                end
            end
            swtps_pkg::S_ICMP:
            begin
                if (cmp_res.eq)
                begin
                    byte_next = byte_reg + 1'b1;
                end
                else
                begin
                    byte_next = '0;
                    if (cmp_res.lt)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            swtps_pkg::S_CPRD:
            begin
                sh_next = count_reg;
            end
            swtps_pkg::S_CPWR:
            begin
                byte_next = byte_reg + 1'b1;
            end
            swtps_pkg::S_SHRD:
            begin
                sh_next = sh_reg;
            end
            swtps_pkg::S_SHWR:
            begin
                sh_next = sh_reg - 1'b1;
            end
            swtps_pkg::S_IDONE:
            begin
                count_next           = count_reg + 1'b1;
                plen_next            = '0;
                strobe_next          = 1'b1;
                result_next.status   = swtps_pkg::ST_STORED;
                result_next.position = pos_reg[5:0];
                result_next.word_len = plen_reg;
                result_next.last     = 1'b1;
            end
            swtps_pkg::S_SRD:
            begin
                if (byte_reg == 6'(klen_reg))
                begin
                    byte_next = '0;
                end
            end
            swtps_pkg::S_SCMP:
            begin
                if (cmp_res.eq)
                begin
                    byte_next = byte_reg + 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            swtps_pkg::S_OUTRD:
            begin
                byte_next = byte_reg;
            end
            swtps_pkg::S_OUTEM:
            begin
                strobe_next          = 1'b1;
                result_next.status   = swtps_pkg::ST_FOUND;
                result_next.position = pos_reg[5:0];
                result_next.word_len = wl_reg;
                result_next.out_char = char_q;
                result_next.last     = (byte_reg + 1'b1 == wl_reg);
                byte_next            = byte_reg + 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= swtps_pkg::S_IDLE;
            count_reg  <= '0;
            plen_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            plen_reg   <= plen_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        sh_reg     <= sh_next;
        byte_reg   <= byte_next;
        slot_reg   <= slot_next;
        wl_reg     <= wl_next;
        search_reg <= search_next;
        key_reg    <= key_next;
        klen_reg   <= klen_next;
        exact_reg  <= exact_next;
        result_reg <= result_next;
    end
endmodule
`default_nettype wire

[sv/swtps_check.sv]
// port level checks for the sorted word table, bound to the top level
`default_nettype none
module swtps_check (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire swtps_pkg::item_t   item,
    input wire logic               strobe,
    input wire swtps_pkg::result_t result
);
    // a streamed word keeps the block busy until its last beat
    a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("beat without last while block idle");

    a_clear_beat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == swtps_pkg::CMD_CLEAR
        |=> strobe && result.status == swtps_pkg::ST_CLEARED && result.last)
        else $error("clear did not answer next cycle");

    a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status == swtps_pkg::ST_MISS |-> result.last)
        else $error("miss beat without last");

    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status == swtps_pkg::ST_FOUND |-> result.word_len != 6'd0)
        else $error("found word of zero length");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != swtps_pkg::ST_FOUND |-> result.out_char == 8'd0)
        else $error("character on a beat that is not a found word");
endmodule

bind sorted_word_table_prefix_search swtps_check u_swtps_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);
`default_nettype wire
